// ===== sv/tcp_cr_pkg.sv =====
// ----------------------------------------------------------------------------
// tcp_cr_pkg: shared types and constants of the TCP client connection engine
// Transaction types, configuration layout, register indexes, flag and state
// codes used by the engine, the configuration block and the output buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package tcp_cr_pkg;

	// default width of the retransmit timeout and alarm counters
	localparam int TIMEOUT_BITS_DEF = 20;

	// opcodes of an input transaction
	localparam logic [1:0] OP_OPEN    = 2'd0;
	localparam logic [1:0] OP_SEGMENT = 2'd1;
	localparam logic [1:0] OP_TICK    = 2'd2;

	// TCP flag bits
	localparam logic [4:0] F_FIN = 5'h01;
	localparam logic [4:0] F_SYN = 5'h02;
	localparam logic [4:0] F_RST = 5'h04;
	localparam logic [4:0] F_PSH = 5'h08;
	localparam logic [4:0] F_ACK = 5'h10;

	// connection states
	localparam logic [2:0] ST_CLOSED      = 3'd0;
	localparam logic [2:0] ST_SYN_SENT    = 3'd1;
	localparam logic [2:0] ST_ESTABLISHED = 3'd2;
	localparam logic [2:0] ST_FIN_SENT    = 3'd3;
	localparam logic [2:0] ST_DONE        = 3'd4;

	// configuration register indexes
	localparam logic [1:0] CFG_INITIAL_SEQUENCE = 2'd0;
	localparam logic [1:0] CFG_INITIAL_TIMEOUT  = 2'd1;
	localparam logic [1:0] CFG_RETRY_LIMIT      = 2'd2;
	localparam logic [1:0] CFG_MESSAGE_LENGTH   = 2'd3;

	// configuration reset values
	localparam logic [31:0] RST_INITIAL_SEQUENCE = 32'd1000;
	localparam logic [15:0] RST_INITIAL_TIMEOUT  = 16'd300;
	localparam logic [3:0]  RST_RETRY_LIMIT      = 4'd5;
	localparam logic [10:0] RST_MESSAGE_LENGTH   = 11'd16;

	// reset value of the current timeout and the largest payload
	localparam int          RST_CURRENT_TIMEOUT = 300;
	localparam logic [10:0] MAX_PAYLOAD         = 11'd1460;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [7:0]  rx_flags;
		logic [31:0] rx_seq;
		logic [31:0] rx_ack;
		logic [15:0] rx_payload_len;
	} in_item_t;

	typedef struct packed {
		logic        tx_valid;
		logic [4:0]  tx_flags;
		logic [31:0] tx_seq;
		logic [31:0] tx_ack;
		logic [10:0] tx_payload_len;
		logic        is_retransmit;
		logic [2:0]  conn_state;
		logic        last;
	} out_item_t;

	typedef struct packed {
		logic [31:0] initial_sequence;
		logic [15:0] initial_timeout_ms;
		logic [3:0]  retry_limit;
		logic [10:0] message_length;
	} cfg_t;

	// header of one segment to send
	typedef struct packed {
		logic [4:0]  flags;
		logic [31:0] seq;
		logic [31:0] ack;
		logic [10:0] len;
		logic        retx;
	} seg_t;

endpackage

`default_nettype wire

// ===== sv/tcp_cr_cfg.sv =====
// ----------------------------------------------------------------------------
// tcp_cr_cfg: configuration registers
// Holds the four software-visible registers and decodes write transactions.
// ----------------------------------------------------------------------------
`default_nettype none

module tcp_cr_cfg
	import tcp_cr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        wr,
	input  wire logic [1:0]  index,
	input  wire logic [31:0] data,
	output cfg_t             cfg
);

	cfg_t cfg_q;

	// write the addressed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.initial_sequence   <= RST_INITIAL_SEQUENCE;
			cfg_q.initial_timeout_ms <= RST_INITIAL_TIMEOUT;
			cfg_q.retry_limit        <= RST_RETRY_LIMIT;
			cfg_q.message_length     <= RST_MESSAGE_LENGTH;
		end else if (wr) begin
			unique case (index)
				CFG_INITIAL_SEQUENCE: cfg_q.initial_sequence   <= data;
				CFG_INITIAL_TIMEOUT:  cfg_q.initial_timeout_ms <= data[15:0];
				CFG_RETRY_LIMIT:      cfg_q.retry_limit        <= data[3:0];
				CFG_MESSAGE_LENGTH:   cfg_q.message_length     <= data[10:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== sv/tcp_cr_engine.sv =====
// ----------------------------------------------------------------------------
// tcp_cr_engine: connection state and segment decision
// Keeps the connection state, sequence numbers, the outstanding segment and
// the retransmit alarm; turns one event into one or two result transactions.
// ----------------------------------------------------------------------------
`default_nettype none

module tcp_cr_engine
	import tcp_cr_pkg::*;
#(
	parameter int TIMEOUT_BITS = TIMEOUT_BITS_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     go,
	input  in_item_t      item,
	input  cfg_t          cfg,
	output out_item_t     res0,
	output out_item_t     res1,
	output logic          two
);

	localparam logic [TIMEOUT_BITS-1:0] TMO_RESET = TIMEOUT_BITS'(RST_CURRENT_TIMEOUT);

	logic [2:0]              state_q;
	logic [31:0]             snd_next_q;
	logic [31:0]             rcv_next_q;
	logic                    payload_sent_q;
	logic                    ost_valid_q;
	logic [4:0]              ost_flags_q;
	logic [31:0]             ost_seq_q;
	logic [31:0]             ost_ack_q;
	logic [10:0]             ost_len_q;
	logic [31:0]             retire_seq_q;
	logic [3:0]              retry_q;
	logic [TIMEOUT_BITS-1:0] cur_tmo_q;
	logic [TIMEOUT_BITS-1:0] alarm_rem_q;
	logic                    alarm_armed_q;

	logic [2:0]              state_n;
	logic [31:0]             snd_next_n;
	logic [31:0]             rcv_next_n;
	logic                    payload_sent_n;
	logic                    ost_valid_n;
	logic [4:0]              ost_flags_n;
	logic [31:0]             ost_seq_n;
	logic [31:0]             ost_ack_n;
	logic [10:0]             ost_len_n;
	logic [31:0]             retire_seq_n;
	logic [3:0]              retry_n;
	logic [TIMEOUT_BITS-1:0] cur_tmo_n;
	logic [TIMEOUT_BITS-1:0] alarm_rem_n;
	logic                    alarm_armed_n;

	seg_t       seg0;
	seg_t       seg1;
	logic [1:0] nres;

	// decide the segments and next state for the held event
	always_comb begin
		logic [4:0]              flags;
		logic [31:0]             ack_diff;
		logic [10:0]             msg_len;
		logic                    dmatch;
		logic                    do_fin;
		logic [31:0]             rcv1;
		logic [31:0]             rcv2;
		logic [TIMEOUT_BITS-1:0] tmo_dbl;
		logic                    st_en;
		logic [4:0]              st_flags;
		logic [31:0]             st_ack;
		logic [10:0]             st_len;
		logic [31:0]             st_consumed;
		seg_t                    fin_seg;

		flags    = item.rx_flags[4:0];
		ack_diff = item.rx_ack - retire_seq_q;
		msg_len  = (cfg.message_length > MAX_PAYLOAD) ? MAX_PAYLOAD : cfg.message_length;
		dmatch   = (item.rx_payload_len != 16'd0) && (item.rx_seq == rcv_next_q);
		do_fin   = flags[0] || (payload_sent_q && (item.rx_payload_len != 16'd0));
		rcv1     = rcv_next_q + (dmatch ? 32'(item.rx_payload_len) : 32'd0);
		rcv2     = rcv1 + 32'(flags[0]);
		tmo_dbl  = cur_tmo_q[TIMEOUT_BITS-1] ? '1 : {cur_tmo_q[TIMEOUT_BITS-2:0], 1'b0};
		fin_seg  = '{flags: F_ACK | F_FIN, seq: snd_next_q, ack: rcv2, len: '0, retx: 1'b0};

		state_n        = state_q;
		snd_next_n     = snd_next_q;
		rcv_next_n     = rcv_next_q;
		payload_sent_n = payload_sent_q;
		ost_valid_n    = ost_valid_q;
		ost_flags_n    = ost_flags_q;
		ost_seq_n      = ost_seq_q;
		ost_ack_n      = ost_ack_q;
		ost_len_n      = ost_len_q;
		retire_seq_n   = retire_seq_q;
		retry_n        = retry_q;
		cur_tmo_n      = cur_tmo_q;
		alarm_rem_n    = alarm_rem_q;
		alarm_armed_n  = alarm_armed_q;
		seg0           = '0;
		seg1           = '0;
		nres           = 2'd0;
		st_en          = 1'b0;
		st_flags       = '0;
		st_ack         = '0;
		st_len         = '0;
		st_consumed    = '0;

		unique case (item.opcode)
			OP_OPEN: begin
				state_n    = ST_SYN_SENT;
				rcv_next_n = '0;
				seg0       = '{flags: F_SYN, seq: cfg.initial_sequence, ack: '0,
					len: '0, retx: 1'b0};
				nres       = 2'd1;
				st_en      = 1'b1;
				st_flags   = F_SYN;
				st_consumed = 32'd1;
			end
			OP_SEGMENT: begin
				if (flags[2]) begin
					state_n = ST_DONE;
				end else begin
					// retire the outstanding segment on a covering acknowledgement
					if (flags[4] && ost_valid_q && !ack_diff[31]) begin
						ost_valid_n   = 1'b0;
						alarm_armed_n = 1'b0;
					end
					if (state_q == ST_SYN_SENT && flags[1] && flags[4]) begin
						rcv_next_n     = item.rx_seq + 32'd1;
						state_n        = ST_ESTABLISHED;
						payload_sent_n = 1'b1;
						seg0 = '{flags: F_ACK, seq: snd_next_q, ack: rcv_next_n,
							len: '0, retx: 1'b0};
						seg1 = '{flags: F_ACK | F_PSH, seq: snd_next_q, ack: rcv_next_n,
							len: msg_len, retx: 1'b0};
						nres = 2'd2;
						if (msg_len != 11'd0) begin
							st_en       = 1'b1;
							st_flags    = F_ACK | F_PSH;
							st_ack      = rcv_next_n;
							st_len      = msg_len;
							st_consumed = 32'(msg_len);
						end
					end else if (state_q == ST_ESTABLISHED) begin
						rcv_next_n = rcv2;
						if (dmatch) begin
							seg0 = '{flags: F_ACK, seq: snd_next_q, ack: rcv1,
								len: '0, retx: 1'b0};
							nres = 2'd1;
						end
						if (do_fin) begin
							if (dmatch) begin
								seg1 = fin_seg;
							end else begin
								seg0 = fin_seg;
							end
							nres        = dmatch ? 2'd2 : 2'd1;
							state_n     = ST_FIN_SENT;
							st_en       = 1'b1;
							st_flags    = F_ACK | F_FIN;
							st_ack      = rcv2;
							st_consumed = 32'd1;
						end
					end else if (state_q == ST_FIN_SENT && flags[4]) begin
						state_n = ST_DONE;
					end
				end
			end
			OP_TICK: begin
				if (alarm_armed_q) begin
					if (alarm_rem_q[TIMEOUT_BITS-1:1] == '0) begin
						alarm_armed_n = 1'b0;
						alarm_rem_n   = '0;
						if (ost_valid_q) begin
							if (retry_q >= cfg.retry_limit) begin
								// give up on the connection
								ost_valid_n = 1'b0;
								state_n     = ST_DONE;
							end else begin
								retry_n       = retry_q + 4'd1;
								seg0 = '{flags: ost_flags_q, seq: ost_seq_q, ack: ost_ack_q,
									len: ost_len_q, retx: 1'b1};
								nres          = 2'd1;
								cur_tmo_n     = tmo_dbl;
								alarm_rem_n   = tmo_dbl;
								alarm_armed_n = 1'b1;
							end
						end
					end else begin
						alarm_rem_n = alarm_rem_q - TIMEOUT_BITS'(1);
					end
				end
			end
			default: ;
		endcase

		// store a segment that consumed sequence space and arm its alarm
		if (st_en) begin
			ost_valid_n   = 1'b1;
			ost_flags_n   = st_flags;
			ost_seq_n     = (item.opcode == OP_OPEN) ? cfg.initial_sequence : snd_next_q;
			ost_ack_n     = st_ack;
			ost_len_n     = st_len;
			retire_seq_n  = ost_seq_n + st_consumed;
			snd_next_n    = retire_seq_n;
			retry_n       = '0;
			cur_tmo_n     = TIMEOUT_BITS'(cfg.initial_timeout_ms);
			alarm_rem_n   = TIMEOUT_BITS'(cfg.initial_timeout_ms);
			alarm_armed_n = 1'b1;
		end else if (item.opcode == OP_OPEN) begin
			snd_next_n = cfg.initial_sequence;
		end
	end

	// build the result transactions
	always_comb begin
		res0 = '0;
		res1 = '0;
		if (nres != 2'd0) begin
			res0.tx_valid       = 1'b1;
			res0.tx_flags       = seg0.flags;
			res0.tx_seq         = seg0.seq;
			res0.tx_ack         = seg0.ack;
			res0.tx_payload_len = seg0.len;
			res0.is_retransmit  = seg0.retx;
		end
		res0.conn_state     = state_n;
		res0.last           = (nres != 2'd2);
		res1.tx_valid       = 1'b1;
		res1.tx_flags       = seg1.flags;
		res1.tx_seq         = seg1.seq;
		res1.tx_ack         = seg1.ack;
		res1.tx_payload_len = seg1.len;
		res1.is_retransmit  = seg1.retx;
		res1.conn_state     = state_n;
		res1.last           = 1'b1;
	end

	assign two = (nres == 2'd2);

	// advance the connection state on each processed event
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLOSED;
			snd_next_q     <= '0;
			rcv_next_q     <= '0;
			payload_sent_q <= 1'b0;
			ost_valid_q    <= 1'b0;
			ost_flags_q    <= '0;
			ost_seq_q      <= '0;
			ost_ack_q      <= '0;
			ost_len_q      <= '0;
			retire_seq_q   <= '0;
			retry_q        <= '0;
			cur_tmo_q      <= TMO_RESET;
			alarm_rem_q    <= '0;
			alarm_armed_q  <= 1'b0;
		end else if (go) begin
			state_q        <= state_n;
			snd_next_q     <= snd_next_n;
			rcv_next_q     <= rcv_next_n;
			payload_sent_q <= payload_sent_n;
			ost_valid_q    <= ost_valid_n;
			ost_flags_q    <= ost_flags_n;
			ost_seq_q      <= ost_seq_n;
			ost_ack_q      <= ost_ack_n;
			ost_len_q      <= ost_len_n;
			retire_seq_q   <= retire_seq_n;
			retry_q        <= retry_n;
			cur_tmo_q      <= cur_tmo_n;
			alarm_rem_q    <= alarm_rem_n;
			alarm_armed_q  <= alarm_armed_n;
		end
	end

endmodule

`default_nettype wire

// ===== sv/tcp_cr_obuf.sv =====
// ----------------------------------------------------------------------------
// tcp_cr_obuf: two-entry result buffer
// Holds the one or two result transactions of an event and presents them in
// order on the output channel; loads again as soon as the last one leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module tcp_cr_obuf
	import tcp_cr_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  load,
	input  out_item_t  res0,
	input  out_item_t  res1,
	input  wire logic  two,
	output logic       can_load,
	output logic       valid,
	input  wire logic  ready,
	output out_item_t  data
);

	out_item_t  buf_q [2];
	logic [1:0] cnt_q;
	logic       pop;

	assign valid    = (cnt_q != 2'd0);
	assign pop      = valid && ready;
	assign can_load = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && ready);
	assign data     = buf_q[0];

	// track the number of held results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load) begin
			cnt_q <= two ? 2'd2 : 2'd1;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	// load a new pair or shift the second result to the head
	always_ff @(posedge clk) begin
		if (load) begin
			buf_q[0] <= res0;
			buf_q[1] <= res1;
		end else if (pop) begin
			buf_q[0] <= buf_q[1];
		end
	end

`ifndef ASSERT_OFF
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("result count out of range");

	a_load_room: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> can_load)
		else $error("load while the buffer has no room");

	a_shift_order: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && (cnt_q == 2'd2) && !load) |=> (valid && (data == $past(buf_q[1]))))
		else $error("second result not presented after the first");

	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && !data.last) |-> (cnt_q == 2'd2))
		else $error("result without last flag has no successor");
`endif

endmodule

`default_nettype wire

// ===== sv/tcp_client_retransmit_fsm.sv =====
// ----------------------------------------------------------------------------
// tcp_client_retransmit_fsm: minimal TCP client connection engine
// Input transactions carry an event: open, received segment header or a
// one millisecond tick. Output transactions carry the header of a segment to
// send (tx_valid 1) or an empty result (tx_valid 0); last marks the final
// result of an event, and an event gives one or two results.
// An accepted event sits in the input register while the engine evaluates it;
// its results are then registered in the two-entry output buffer and offered
// from there.
// Throughput is one event per cycle while each event gives one result and the
// receiver keeps ready high; an event with two results holds the two-entry
// output buffer until its second result leaves, which sets the rate for such events.
// When the receiver stalls, results wait in the output buffer, one more event
// waits in the input register, and in_ready falls until room appears.
// Configuration writes are always ready and take effect on the next cycle.
// Reset clears the connection to closed with nothing outstanding and loads
// the register defaults; no results are pending after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module tcp_client_retransmit_fsm
	import tcp_cr_pkg::*;
#(
	parameter int TIMEOUT_BITS = TIMEOUT_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  in_item_t         in_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output out_item_t        out_data,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	in_item_t  item_s1;
	logic      valid_s1;
	logic      take;
	logic      can_load;
	cfg_t      cfg;
	out_item_t res0;
	out_item_t res1;
	logic      two;

	assign cfg_ready = 1'b1;
	assign take      = valid_s1 && can_load;
	assign in_ready  = !valid_s1 || take;

	// hold the accepted event until the engine takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	tcp_cr_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (cfg_valid && cfg_ready),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	tcp_cr_engine #(
		.TIMEOUT_BITS (TIMEOUT_BITS)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (take),
		.item   (item_s1),
		.cfg    (cfg),
		.res0   (res0),
		.res1   (res1),
		.two    (two)
	);

	tcp_cr_obuf u_obuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (take),
		.res0     (res0),
		.res1     (res1),
		.two      (two),
		.can_load (can_load),
		.valid    (out_valid),
		.ready    (out_ready),
		.data     (out_data)
	);

endmodule

`default_nettype wire

// ===== tb/tcp_cr_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tcp_cr_checker: scoreboard of the TCP client connection engine
// Watches the event, result and register write channels. Keeps its own model
// of the connection (state, sequence numbers, outstanding segment, alarm),
// works out the results of every accepted event and compares each accepted
// result, field by field, with the oldest one still due.
// ----------------------------------------------------------------------------
module tcp_cr_checker
	import tcp_cr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_ready,
	input  in_item_t         in_data,
	input  wire logic        out_valid,
	input  wire logic        out_ready,
	input  out_item_t        out_data,
	input  wire logic        cfg_valid,
	input  wire logic        cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	output int               mismatches,
	output int               results_due,
	output int               results_seen
);

	localparam int            TB       = TIMEOUT_BITS_DEF;
	localparam logic [TB-1:0] RTO_CEIL = '1;

	// register copies
	logic [31:0]   isn_reg;
	logic [15:0]   rto_init_reg;
	logic [3:0]    retry_lim_reg;
	logic [10:0]   msg_len_reg;

	// connection model
	logic [2:0]    conn;
	logic [31:0]   snd_nxt;
	logic [31:0]   rcv_nxt;
	logic          data_sent;
	logic          held_ok;
	logic [4:0]    held_flags;
	logic [31:0]   held_seq;
	logic [31:0]   held_ack;
	logic [10:0]   held_len;
	logic [31:0]   retire_at;
	logic [3:0]    retries;
	logic [TB-1:0] rto;
	logic [TB-1:0] alarm_left;
	logic          alarm_on;

	// segments produced by the event under evaluation
	seg_t          segs [2];
	int            nsegs;

	out_item_t     due_results [$];

	// record one segment header of the current event
	task automatic emit_segment(logic [4:0] fl, logic [31:0] sq, logic [31:0] ak,
			logic [10:0] len, logic retx);
		if (nsegs < 2) begin
			segs[nsegs] = {fl, sq, ak, len, retx};
			nsegs++;
		end
	endtask

	// send a new segment; hold it as outstanding when it uses sequence space
	task automatic transmit(logic [4:0] fl, logic [10:0] len);
		logic [31:0] used;
		used = 32'(len);
		if ((fl & (F_SYN | F_FIN)) != 0)
			used = used + 32'd1;
		emit_segment(fl, snd_nxt, rcv_nxt, len, 1'b0);
		if (used != 0) begin
			held_ok    = 1'b1;
			held_flags = fl;
			held_seq   = snd_nxt;
			held_ack   = rcv_nxt;
			held_len   = len;
			retire_at  = snd_nxt + used;
			retries    = '0;
			rto        = TB'(rto_init_reg);
			alarm_left = rto;
			alarm_on   = 1'b1;
		end
		snd_nxt = snd_nxt + used;
	endtask

	// alarm expiry: give up at the retry limit, else resend and back off
	task automatic alarm_expired();
		logic [TB:0] doubled;
		if (!held_ok)
			return;
		if (retries >= retry_lim_reg) begin
			held_ok = 1'b0;
			conn    = ST_DONE;
			return;
		end
		retries = retries + 4'd1;
		emit_segment(held_flags, held_seq, held_ack, held_len, 1'b1);
		doubled    = {rto, 1'b0};
		rto        = (doubled > {1'b0, RTO_CEIL}) ? RTO_CEIL : doubled[TB-1:0];
		alarm_left = rto;
		alarm_on   = 1'b1;
	endtask

	// received segment header
	task automatic segment_rx(in_item_t it);
		logic [4:0]  fl;
		logic [31:0] gap;
		logic [10:0] ml;
		fl  = it.rx_flags[4:0];
		if ((fl & F_RST) != 0) begin
			conn = ST_DONE;
			return;
		end
		// retire the outstanding segment on an ack at or past its end
		gap = it.rx_ack - retire_at;
		if ((fl & F_ACK) != 0 && held_ok && !gap[31]) begin
			held_ok  = 1'b0;
			alarm_on = 1'b0;
		end
		if (conn == ST_SYN_SENT && (fl & F_SYN) != 0 && (fl & F_ACK) != 0) begin
			ml      = (msg_len_reg > MAX_PAYLOAD) ? MAX_PAYLOAD : msg_len_reg;
			rcv_nxt = it.rx_seq + 32'd1;
			conn    = ST_ESTABLISHED;
			transmit(F_ACK, 11'd0);
			transmit(F_ACK | F_PSH, ml);
			data_sent = 1'b1;
			return;
		end
		if (conn == ST_ESTABLISHED) begin
			if (it.rx_payload_len != 0 && it.rx_seq == rcv_nxt) begin
				rcv_nxt = rcv_nxt + 32'(it.rx_payload_len);
				transmit(F_ACK, 11'd0);
			end
			if ((fl & F_FIN) != 0) begin
				rcv_nxt = rcv_nxt + 32'd1;
				transmit(F_ACK | F_FIN, 11'd0);
				conn = ST_FIN_SENT;
			end else if (data_sent && it.rx_payload_len != 0) begin
				transmit(F_ACK | F_FIN, 11'd0);
				conn = ST_FIN_SENT;
			end
			return;
		end
		if (conn == ST_FIN_SENT && (fl & F_ACK) != 0)
			conn = ST_DONE;
	endtask

	// evaluate one event and queue the results it is due to give
	task automatic step_connection(in_item_t it);
		out_item_t r;
		nsegs = 0;
		case (it.opcode)
			OP_OPEN: begin
				snd_nxt = isn_reg;
				rcv_nxt = '0;
				conn    = ST_SYN_SENT;
				transmit(F_SYN, 11'd0);
			end
			OP_SEGMENT: segment_rx(it);
			OP_TICK: begin
				if (alarm_on) begin
					if (alarm_left <= TB'(1)) begin
						alarm_on   = 1'b0;
						alarm_left = '0;
						alarm_expired();
					end else begin
						alarm_left = alarm_left - TB'(1);
					end
				end
			end
			default: ;
		endcase
		if (nsegs == 0) begin
			r            = '0;
			r.conn_state = conn;
			r.last       = 1'b1;
			due_results.push_back(r);
		end else begin
			for (int k = 0; k < nsegs; k++) begin
				r                = '0;
				r.tx_valid       = 1'b1;
				r.tx_flags       = segs[k].flags;
				r.tx_seq         = segs[k].seq;
				r.tx_ack         = segs[k].ack;
				r.tx_payload_len = segs[k].len;
				r.is_retransmit  = segs[k].retx;
				r.conn_state     = conn;
				r.last           = (k == nsegs - 1);
				due_results.push_back(r);
			end
		end
	endtask

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t ns: result %0d, %s expected 0x%0h, got 0x%0h",
				$time, results_seen, name, want, got);
		end
	endtask

	// watch the three channels
	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			isn_reg       = RST_INITIAL_SEQUENCE;
			rto_init_reg  = RST_INITIAL_TIMEOUT;
			retry_lim_reg = RST_RETRY_LIMIT;
			msg_len_reg   = RST_MESSAGE_LENGTH;
			conn          = ST_CLOSED;
			snd_nxt       = '0;
			rcv_nxt       = '0;
			data_sent     = 1'b0;
			held_ok       = 1'b0;
			held_flags    = '0;
			held_seq      = '0;
			held_ack      = '0;
			held_len      = '0;
			retire_at     = '0;
			retries       = '0;
			rto           = TB'(RST_CURRENT_TIMEOUT);
			alarm_left    = '0;
			alarm_on      = 1'b0;
			due_results.delete();
			results_due  <= 0;
		end else begin
			// register write
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_INITIAL_SEQUENCE: isn_reg       = cfg_data;
					CFG_INITIAL_TIMEOUT:  rto_init_reg  = cfg_data[15:0];
					CFG_RETRY_LIMIT:      retry_lim_reg = cfg_data[3:0];
					CFG_MESSAGE_LENGTH:   msg_len_reg   = cfg_data[10:0];
					default: ;
				endcase
			end
			// result transaction against the oldest due result
			if (out_valid && out_ready) begin
				if (due_results.size() == 0) begin
					mismatches++;
					$display("%0t ns: unexpected result, expected none, got 0x%0h",
						$time, out_data);
				end else begin
					want = due_results.pop_front();
					check_field("tx_valid", want.tx_valid, out_data.tx_valid);
					check_field("tx_flags", want.tx_flags, out_data.tx_flags);
					check_field("tx_seq", want.tx_seq, out_data.tx_seq);
					check_field("tx_ack", want.tx_ack, out_data.tx_ack);
					check_field("tx_payload_len", want.tx_payload_len,
						out_data.tx_payload_len);
					check_field("is_retransmit", want.is_retransmit, out_data.is_retransmit);
					check_field("conn_state", want.conn_state, out_data.conn_state);
					check_field("last", want.last, out_data.last);
				end
				results_seen++;
			end
			// event transaction
			if (in_valid && in_ready)
				step_connection(in_data);
			results_due <= due_results.size();
		end
	end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: top level of the TCP client connection engine test
// Drives open, segment and tick events and register writes, with random idle
// cycles on both channels, a stretch without idling and one long receiver
// hold-off. A directed opening covers the corner cases; the bulk is connection
// sequences with random content, mixed with noise, under changing settings.
// ----------------------------------------------------------------------------
module testbench;
	import tcp_cr_pkg::*;

	localparam logic [1:0] OP_UNUSED     = 2'd3;
	localparam int         RANDOM_EVENTS = 1500;
	localparam int         PHASE_EVENTS  = 150;
	localparam int         STALL_CYCLES  = 400;
	localparam int         CYCLE_LIMIT   = 400000;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	in_item_t    in_data   = '0;
	logic        out_ready = 1'b0;
	logic        cfg_valid = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [31:0] cfg_data  = '0;
	logic        in_ready;
	logic        out_valid;
	out_item_t   out_data;
	logic        cfg_ready;

	int          mismatches;
	int          results_due;
	int          results_seen;

	int          cycles      = 0;
	int          events_sent = 0;
	int          settings    = 0;
	bit          quiet       = 1'b0;
	bit          stall_req   = 1'b0;
	bit          stall_done  = 1'b0;

	// settings as last written, used to shape the sequences
	logic [31:0] cur_isn;
	int          cur_rto;
	int          cur_ml;

	tcp_client_retransmit_fsm uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	tcp_cr_checker conn_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.in_data      (in_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_data     (out_data),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.mismatches   (mismatches),
		.results_due  (results_due),
		.results_seen (results_seen)
	);

	always #4 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("[tcp_client_retransmit_fsm] ERROR");
			$finish;
		end
	end

	// receiver: random stalls, one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (stall_req && !stall_done) begin
				out_ready <= 1'b0;
				repeat (STALL_CYCLES) @(posedge clk);
				stall_done = 1'b1;
			end
			out_ready <= quiet || ($urandom_range(99) >= 23);
		end
	end

	// offer one event and hold it until accepted
	task automatic offer(logic [1:0] op, logic [7:0] fl, logic [31:0] sq, logic [31:0] ak,
			logic [15:0] len);
		if (!quiet) begin
			while ($urandom_range(99) < 23) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		in_data  <= {op, fl, sq, ak, len};
		do @(posedge clk); while (!in_ready);
		events_sent++;
	endtask

	// write one register once every due result has arrived
	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		logic [31:0] junk;
		junk = $urandom;
		// fill the unused upper bits with noise
		case (idx)
			CFG_INITIAL_TIMEOUT: val = {junk[31:16], val[15:0]};
			CFG_RETRY_LIMIT:     val = {junk[31:4], val[3:0]};
			CFG_MESSAGE_LENGTH:  val = {junk[31:11], val[10:0]};
			default: ;
		endcase
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_due != 0) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic apply_setting(logic [31:0] isn, int rto0, int lim, int ml);
		write_reg(CFG_INITIAL_SEQUENCE, isn);
		write_reg(CFG_INITIAL_TIMEOUT, rto0);
		write_reg(CFG_RETRY_LIMIT, lim);
		write_reg(CFG_MESSAGE_LENGTH, ml);
		cur_isn = isn;
		cur_rto = rto0;
		cur_ml  = ml;
		settings++;
	endtask

	// a burst of ticks, at times long enough to reach the alarm when the timeout is short
	task automatic ticks();
		int n;
		n = (cur_rto <= 8) ? $urandom_range(0, 2 * cur_rto + 2) : $urandom_range(0, 3);
		repeat (n) offer(OP_TICK, $urandom, $urandom, $urandom, $urandom);
	endtask

	initial begin
		int          p;
		int          next_change;
		int          quiet_from;
		int          stall_from;
		int          target;
		int          ml;
		int          t;
		int          l;
		int          m;
		logic [31:0] s;
		logic [31:0] peer;
		logic [31:0] c_isn;
		logic [7:0]  fl;
		logic [15:0] dlen;

		cur_isn = RST_INITIAL_SEQUENCE;
		cur_rto = RST_INITIAL_TIMEOUT;
		cur_ml  = RST_MESSAGE_LENGTH;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// unknown opcode, idle tick, reset flag while closed
		offer(OP_UNUSED, 8'hFF, '1, '1, 16'hFFFF);
		offer(OP_TICK, 8'h00, '0, '0, 16'h0000);
		offer(OP_SEGMENT, 8'hFF, '1, '1, 16'hFFFF);
		// open, then open again to restart the handshake
		offer(OP_OPEN, 8'h00, '0, '0, 16'h0000);
		offer(OP_OPEN, 8'hFF, '1, '1, 16'hFFFF);
		// establish with the receive number wrapping to zero
		offer(OP_SEGMENT, {3'b111, F_SYN | F_ACK}, '1, 32'd1001, 16'h0000);
		offer(OP_TICK, 8'hFF, '1, '1, 16'hFFFF);
		// ack the data, in-order data of the largest size: ack and fin follow
		offer(OP_SEGMENT, 8'(F_ACK), 32'd0, 32'd1017, 16'hFFFF);
		offer(OP_SEGMENT, 8'(F_ACK), 32'd0, 32'd1018, 16'h0000);
		// reset flag in the middle of the handshake, then a segment while done
		offer(OP_OPEN, 8'h00, '0, '0, 16'h0000);
		offer(OP_SEGMENT, 8'(F_SYN | F_ACK | F_RST), 32'h5, 32'd1001, 16'h0);
		offer(OP_SEGMENT, 8'(F_SYN | F_ACK), 32'h5, 32'd1001, 16'h0);
		// zero timeout with no retries allowed: give up on the first tick
		apply_setting(32'd1000, 0, 0, 16);
		offer(OP_OPEN, 8'h00, '0, '0, 16'h0000);
		offer(OP_TICK, 8'h00, '0, '0, 16'h0000);
		// one retry, then give up after the doubled timeout
		apply_setting(32'hFFFF_FFFF, 1, 1, 0);
		offer(OP_OPEN, 8'h00, '0, '0, 16'h0000);
		offer(OP_TICK, 8'h00, '0, '0, 16'h0000);
		offer(OP_TICK, 8'h00, '0, '0, 16'h0000);
		offer(OP_TICK, 8'h00, '0, '0, 16'h0000);

		// random part: connection sequences with random content, plus noise
		p           = 0;
		next_change = events_sent;
		target      = events_sent + RANDOM_EVENTS;
		quiet_from  = events_sent + 500;
		stall_from  = events_sent + 1000;
		while (events_sent < target) begin
			if (events_sent >= next_change) begin
				p++;
				case (p % 4)
					0: s = '0;
					1: s = '1;
					2: s = 32'hFFFF_FFF8;
					default: s = $urandom;
				endcase
				t = (p == 1) ? 0 : (p == 2) ? 65535 : $urandom_range(1, 6);
				l = (p % 3 == 0) ? 0 : (p % 3 == 1) ? 15 : $urandom_range(1, 4);
				case (p % 5)
					0: m = 0;
					1: m = 1460;
					2: m = $urandom_range(1461, 2047);
					3: m = 1;
					default: m = $urandom_range(1, 1460);
				endcase
				apply_setting(s, t, l, m);
				next_change = events_sent + PHASE_EVENTS;
			end
			quiet = (events_sent >= quiet_from) && (events_sent < quiet_from + 200);
			if (!stall_req && events_sent >= stall_from)
				stall_req = 1'b1;

			if ($urandom_range(99) < 85) begin
				c_isn = cur_isn;
				peer  = $urandom;
				ml    = (cur_ml > 1460) ? 1460 : cur_ml;
				offer(OP_OPEN, $urandom, $urandom, $urandom, $urandom);
				ticks();
				// answer the SYN, at times with a wrong ack, stray bits or a reset
				fl      = 8'(F_SYN | F_ACK);
				fl[7:5] = $urandom;
				if ($urandom_range(3) == 0)
					fl = fl | 8'(F_PSH);
				if ($urandom_range(14) == 0)
					fl = fl | 8'(F_RST);
				if ($urandom_range(19) == 0)
					fl = fl & ~8'(F_SYN);
				offer(OP_SEGMENT, fl, peer, ($urandom_range(4) == 0) ? $urandom : c_isn + 1,
					($urandom_range(3) == 0) ? $urandom_range(0, 8) : 0);
				ticks();
				// acknowledge the data segment, now and then short of its end
				if ($urandom_range(3) != 0)
					offer(OP_SEGMENT, 8'(F_ACK), peer + 1,
						c_isn + 1 + ml - (($urandom_range(2) == 0) ? $urandom_range(1, 3) : 0),
						16'h0000);
				ticks();
				// peer data, mostly in order, with or without FIN
				dlen = ($urandom_range(3) == 0) ? 0 :
					($urandom_range(9) == 0) ? $urandom : $urandom_range(1, 64);
				fl      = 8'(F_ACK);
				fl[7:5] = $urandom;
				if ($urandom_range(2) == 0)
					fl = fl | 8'(F_FIN);
				offer(OP_SEGMENT, fl, ($urandom_range(4) == 0) ? $urandom : peer + 1,
					c_isn + 1 + ml, dlen);
				ticks();
				// acknowledge the FIN
				if ($urandom_range(4) != 0)
					offer(OP_SEGMENT, 8'(F_ACK), peer + 2 + dlen, c_isn + 2 + ml, 16'h0000);
				ticks();
			end else begin
				repeat ($urandom_range(1, 5))
					offer($urandom_range(3), $urandom, $urandom, $urandom, $urandom);
			end
		end
		quiet = 1'b0;

		// drain
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_due != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("Covered %0d events: corner cases and connection sequences under %0d settings.",
			events_sent, settings);
		$display("Compared %0d results, %0d mismatches.", results_seen, mismatches);
		if (mismatches == 0 && results_due == 0)
			$display("[tcp_client_retransmit_fsm] OK");
		else
			$display("[tcp_client_retransmit_fsm] ERROR");
		$finish;
	end

endmodule

// ===== tcp_client_retransmit_fsm.f =====
sv/tcp_cr_pkg.sv
sv/tcp_cr_cfg.sv
sv/tcp_cr_engine.sv
sv/tcp_cr_obuf.sv
sv/tcp_client_retransmit_fsm.sv
tb/tcp_cr_checker.sv
tb/testbench.sv
